// ===== sv/btpc_pkg.sv =====
package btpc_pkg;

	// Width of the pressure path and of the quotient.
	localparam int unsigned DIV_W = 64;

	// Values that ride along with a request through the divider.
	typedef struct packed {
		logic [31:0] temp;
		logic        dz;
		logic        neg;
	} sb_t;

endpackage

// ===== sv/baro_temp_pressure_compensation.sv =====
// Integer temperature and pressure compensation for a digital barometer. Each request
// carries one raw temperature and one raw pressure reading; busy stays low, so a request
// is taken in every cycle that start is high. The result appears on the result ports,
// marked by done, for one cycle, and one result leaves per cycle. The path runs through ten
// stages of calibration arithmetic, a 65-stage restoring divider (a magnitude stage, then one
// quotient bit per stage) and five stages of final pressure correction. The receiver cannot
// stall, so nothing is held back. Calibration registers are written through the APB port
// while no request is in flight; the user must ensure this, the block does not enforce it.
module baro_temp_pressure_compensation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic [19:0]        raw_temperature,
	input  logic [19:0]        raw_pressure,
	output logic               done,
	output logic signed [31:0] temperature_centi,
	output logic [31:0]        pressure_q24_8,
	output logic               divisor_zero
);

	typedef enum logic [2:0] {
		REG_T1  = 3'd0,
		REG_T2  = 3'd1,
		REG_T3  = 3'd2,
		REG_P1  = 3'd3,
		REG_P23 = 3'd4,
		REG_P45 = 3'd5,
		REG_P67 = 3'd6,
		REG_P89 = 3'd7
	} reg_idx_t;

	localparam int unsigned LAT = 80;

	logic [15:0] cal_t1_q, cal_t2_q, cal_t3_q, cal_p1_q;
	logic [31:0] cal_p2_p3_q, cal_p4_p5_q, cal_p6_p7_q, cal_p8_p9_q;
	reg_idx_t    widx;
	logic        accept;

	assign widx   = reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t1_q    <= '0;
			cal_t2_q    <= '0;
			cal_t3_q    <= '0;
			cal_p1_q    <= '0;
			cal_p2_p3_q <= '0;
			cal_p4_p5_q <= '0;
			cal_p6_p7_q <= '0;
			cal_p8_p9_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (widx)
				REG_T1:  cal_t1_q    <= pwdata[15:0];
				REG_T2:  cal_t2_q    <= pwdata[15:0];
				REG_T3:  cal_t3_q    <= pwdata[15:0];
				REG_P1:  cal_p1_q    <= pwdata[15:0];
				REG_P23: cal_p2_p3_q <= pwdata;
				REG_P45: cal_p4_p5_q <= pwdata;
				REG_P67: cal_p6_p7_q <= pwdata;
				REG_P89: cal_p8_p9_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_T1:  prdata = {16'd0, cal_t1_q};
			REG_T2:  prdata = {16'd0, cal_t2_q};
			REG_T3:  prdata = {16'd0, cal_t3_q};
			REG_P1:  prdata = {16'd0, cal_p1_q};
			REG_P23: prdata = cal_p2_p3_q;
			REG_P45: prdata = cal_p4_p5_q;
			REG_P67: prdata = cal_p6_p7_q;
			REG_P89: prdata = cal_p8_p9_q;
			default: prdata = '0;
		endcase
	end

	logic signed [15:0] t2, t3, p2, p3, p5, p6, p8, p9;
	logic signed [63:0] p4_x;
	logic        [31:0] p7_sh;

	assign t2    = cal_t2_q;
	assign t3    = cal_t3_q;
	assign p2    = cal_p2_p3_q[15:0];
	assign p3    = cal_p2_p3_q[31:16];
	assign p5    = cal_p4_p5_q[31:16];
	assign p6    = cal_p6_p7_q[15:0];
	assign p8    = cal_p8_p9_q[15:0];
	assign p9    = cal_p8_p9_q[31:16];
	assign p4_x  = {{48{cal_p4_p5_q[15]}}, cal_p4_p5_q[15:0]};
	assign p7_sh = {{12{cal_p6_p7_q[31]}}, cal_p6_p7_q[31:16], 4'd0};

	btpc_pkg::sb_t dv_in_sb, dv_sb;
	logic          dv_valid;
	logic [63:0]   dv_quot;

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic               vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic               vld_s11, vld_s12, vld_s13, vld_s14, vld_s15;

	logic signed [17:0] a_s1;
	logic signed [16:0] b_s1;
	logic signed [31:0] m1_s2, bb_s2, v1t_s3, m2_s3, fine_s4;
	logic signed [31:0] temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10;
	logic signed [32:0] x_s5;
	logic        [19:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6, adcp_s7, adcp_s8;
	logic signed [63:0] xx_s6, xp5_s6, xp2_s6;
	logic signed [63:0] v2a_s7, v1a_s7, xp5_s7, xp2_s7;
	logic signed [63:0] v2_s8, v1b_s8;
	logic signed [63:0] v1m_s9;
	logic        [63:0] num0_s9;
	logic signed [63:0] v1_s10;
	logic        [63:0] num_s10;
	logic        [20:0] pd;

	assign pd = 21'h100000 - {1'b0, adcp_s8};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
		end else begin
			vld_s1  <= accept;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= dv_valid;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
		end
	end

	// Temperature path, mostly in 32-bit wrapping arithmetic; the offset term x_s5 is 33 bits wide.
	always_ff @(posedge clk) begin
		a_s1    <= $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cal_t1_q, 1'b0});
		b_s1    <= $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cal_t1_q});
		adcp_s1 <= raw_pressure;

		m1_s2   <= a_s1 * t2;
		bb_s2   <= b_s1 * b_s1;
		adcp_s2 <= adcp_s1;

		v1t_s3  <= m1_s2 >>> 11;
		m2_s3   <= (bb_s2 >>> 12) * t3;
		adcp_s3 <= adcp_s2;

		fine_s4 <= v1t_s3 + (m2_s3 >>> 14);
		adcp_s4 <= adcp_s3;

		temp_s5 <= (fine_s4 * 32'sd5 + 32'sd128) >>> 8;
		x_s5    <= fine_s4 - 33'sd128000;
		adcp_s5 <= adcp_s4;
	end

	// Pressure path up to the division, in 64-bit wrapping arithmetic.
	always_ff @(posedge clk) begin
		xx_s6   <= x_s5 * x_s5;
		xp5_s6  <= x_s5 * p5;
		xp2_s6  <= x_s5 * p2;
		temp_s6 <= temp_s5;
		adcp_s6 <= adcp_s5;

		v2a_s7  <= xx_s6 * p6;
		v1a_s7  <= xx_s6 * p3;
		xp5_s7  <= xp5_s6;
		xp2_s7  <= xp2_s6;
		temp_s7 <= temp_s6;
		adcp_s7 <= adcp_s6;

		v2_s8   <= v2a_s7 + (xp5_s7 <<< 17) + (p4_x <<< 35);
		v1b_s8  <= (v1a_s7 >>> 8) + (xp2_s7 <<< 12);
		temp_s8 <= temp_s7;
		adcp_s8 <= adcp_s7;

		v1m_s9  <= $signed(($unsigned(v1b_s8) + (64'd1 << 47)) * {48'd0, cal_p1_q});
		num0_s9 <= ({43'd0, pd} << 31) - $unsigned(v2_s8);
		temp_s9 <= temp_s8;

		v1_s10   <= v1m_s9 >>> 33;
		num_s10  <= num0_s9 * 64'd3125;
		temp_s10 <= temp_s9;
	end

	always_comb begin
		dv_in_sb.temp = temp_s10;
		dv_in_sb.dz   = (v1_s10 == 64'sd0);
		dv_in_sb.neg  = 1'b0;
	end

	btpc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s10),
		.num      (num_s10),
		.den      ($unsigned(v1_s10)),
		.in_sb    (dv_in_sb),
		.out_valid(dv_valid),
		.quot     (dv_quot),
		.out_sb   (dv_sb)
	);

	logic signed [63:0] p_s11, p_s12, p_s13, p_s14;
	logic signed [63:0] ph, p9ph_s12, p8p_s12, ph_s12;
	logic        [63:0] ll_s13;
	logic        [31:0] lh_s13, hl_s13;
	logic signed [63:0] v2c_s13, v2c_s14, v1c_s14;
	logic        [63:0] sum_all;
	logic        [31:0] pres_s15;
	btpc_pkg::sb_t      sb_s11, sb_s12, sb_s13, sb_s14, sb_s15;

	assign ph      = p_s11 >>> 13;
	assign sum_all = $unsigned(p_s14 + v1c_s14 + v2c_s14);

	// Final correction; the 64 by 64 square term is built from 32-bit partial products.
	always_ff @(posedge clk) begin
		p_s11    <= dv_sb.neg ? $signed(64'd0 - dv_quot) : $signed(dv_quot);
		sb_s11   <= dv_sb;

		p9ph_s12 <= p9 * ph;
		p8p_s12  <= p_s11 * p8;
		ph_s12   <= ph;
		p_s12    <= p_s11;
		sb_s12   <= sb_s11;

		ll_s13   <= p9ph_s12[31:0] * ph_s12[31:0];
		lh_s13   <= p9ph_s12[31:0] * ph_s12[63:32];
		hl_s13   <= p9ph_s12[63:32] * ph_s12[31:0];
		v2c_s13  <= p8p_s12 >>> 19;
		p_s13    <= p_s12;
		sb_s13   <= sb_s12;

		v1c_s14  <= $signed(ll_s13 + {lh_s13 + hl_s13, 32'd0}) >>> 25;
		v2c_s14  <= v2c_s13;
		p_s14    <= p_s13;
		sb_s14   <= sb_s13;

		pres_s15 <= sb_s14.dz ? 32'd0 : (sum_all[39:8] + p7_sh);
		sb_s15   <= sb_s14;
	end

	assign done              = vld_s15;
	assign temperature_centi = sb_s15.temp;
	assign pressure_q24_8    = pres_s15;
	assign divisor_zero      = sb_s15.dz;

`ifndef SYNTHESIS
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without a matching request");
	a_dz_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		(done && divisor_zero) |-> (pressure_q24_8 == 32'd0))
		else $error("pressure not forced to zero on zero divisor");
	a_dz_source: assert property (@(posedge clk) disable iff (!arst_n)
		(done && divisor_zero) |-> $past(v1_s10 == 64'sd0, LAT - 10))
		else $error("zero divisor flag does not match the divisor");
`endif

endmodule

// ===== sv/btpc_divider.sv =====
module btpc_divider (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [btpc_pkg::DIV_W-1:0]       num,
	input  logic [btpc_pkg::DIV_W-1:0]       den,
	input  btpc_pkg::sb_t                    in_sb,
	output logic                             out_valid,
	output logic [btpc_pkg::DIV_W-1:0]       quot,
	output btpc_pkg::sb_t                    out_sb
);

	localparam int unsigned W = btpc_pkg::DIV_W;

	// Stage 0 holds the magnitudes; stages 1 to W each retire one quotient bit.
	logic [W:0]    vld_s;
	logic [W-1:0]  rem_s [0:W];
	logic [W-1:0]  nq_s  [0:W];
	logic [W-1:0]  md_s  [0:W];
	btpc_pkg::sb_t sb_s  [0:W];

	logic [W-1:0]  rem_nx [0:W-1];
	logic [W-1:0]  nq_nx  [0:W-1];

	always_comb begin
		logic [W:0] pre;
		logic [W:0] diff;
		pre  = '0;
		diff = '0;
		for (int k = 0; k < W; k++) begin
			pre  = {rem_s[k], nq_s[k][W-1]};
			diff = pre - {1'b0, md_s[k]};
			if (!diff[W]) begin
				rem_nx[k] = diff[W-1:0];
				nq_nx[k]  = {nq_s[k][W-2:0], 1'b1};
			end else begin
				rem_nx[k] = pre[W-1:0];
				nq_nx[k]  = {nq_s[k][W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[W-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]    <= '0;
		nq_s[0]     <= num[W-1] ? ({W{1'b0}} - num) : num;
		md_s[0]     <= den[W-1] ? ({W{1'b0}} - den) : den;
		sb_s[0].temp <= in_sb.temp;
		sb_s[0].dz   <= in_sb.dz;
		sb_s[0].neg  <= num[W-1] ^ den[W-1];
		for (int k = 0; k < W; k++) begin
			rem_s[k+1] <= rem_nx[k];
			nq_s[k+1]  <= nq_nx[k];
			md_s[k+1]  <= md_s[k];
			sb_s[k+1]  <= sb_s[k];
		end
	end

	assign out_valid = vld_s[W];
	assign quot      = nq_s[W];
	assign out_sb    = sb_s[W];

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(in_valid, W+1))
		else $error("divider result without a request");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && md_s[W] != '0) |-> (rem_s[W] < md_s[W]))
		else $error("divider remainder out of range");
	a_sideband: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_sb.temp == $past(in_sb.temp, W+1) &&
			out_sb.dz == $past(in_sb.dz, W+1)))
		else $error("divider sideband misaligned");
`endif

endmodule
